### hw/rtl/quadratic_spline_fit_and_eval_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the spline block.
// ============================================================================
`ifndef QUADRATIC_SPLINE_FIT_AND_EVAL_MACROS_SVH
`define QUADRATIC_SPLINE_FIT_AND_EVAL_MACROS_SVH

// Same-cycle implication.
`define QSF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define QSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/qsf_pkg.sv
// ============================================================================
// Spline package
// Types, codes, widths and helper functions of the quadratic spline block.
// ============================================================================
package qsf_pkg;

  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int MCW = 80;
  localparam int MPW = 33;
  localparam int PW  = MCW + MPW;
  localparam int DNW = 128;
  localparam int DDW = 33;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EVAL  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_FULL = 2'd1,
    ERR_ZERO = 2'd2,
    ERR_FEW  = 2'd3
  } err_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_KNOT,
    ST_LD_CHK,
    ST_LD_PREV,
    ST_LD_HP,
    ST_LD_B,
    ST_LD_NUM,
    ST_LD_WR,
    ST_MUL,
    ST_MUL_WAIT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_EV_ISSUE,
    ST_EV_CHK,
    ST_EV_SEG_RD,
    ST_EV_SEG,
    ST_EV_SUM,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_AHP,
    PH_BH,
    PH_DB,
    PH_DA1,
    PH_DA2,
    PH_EA1,
    PH_EA2,
    PH_EB
  } phase_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } knot_t;

  typedef struct packed {
    logic signed [47:0] a;
    logic signed [47:0] b;
  } coef_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic [127:0] mag128(input logic signed [127:0] v);
    return v[127] ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic signed [127:0] sgn128(input logic [127:0] m, input logic n);
    return n ? $signed(-m) : $signed(m);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [127:0] v);
    if ((v[127:47] == '0) || (v[127:47] == '1)) begin
      return v[47:0];
    end
    return v[127] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
    if ((v[127:31] == '0) || (v[127:31] == '1)) begin
      return v[31:0];
    end
    return v[127] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

endpackage

### hw/rtl/quadratic_spline_fit_and_eval.sv
// ============================================================================
// Quadratic spline fit and evaluate
// Knot table, coefficient table and sequencer of the spline block.
// ============================================================================
// The time a request takes, from the accepting edge to the edge that presents
// its result, depends on the request. Clear, a load into a full table, an
// unused operation code and an evaluation with fewer than two knots go straight
// to the result, the first knot is written at once and a load with zero spacing
// stops after the spacing check. The second knot takes one pass of the 128-step
// serial divider; every later knot takes two 33-step serial multiplications
// followed by two divider passes. An evaluation reads one stored abscissa at a
// time from the knot memory until a segment encloses the query, then runs three
// serial multiplications; a query that misses every segment reads every stored
// knot. A new request is taken while the previous result still waits at the
// output.
`include "quadratic_spline_fit_and_eval_macros.svh"

module quadratic_spline_fit_and_eval #(
  parameter int MAX_KNOTS = qsf_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = qsf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] spline_value,
  output logic               found,
  output logic [1:0]         error_code,
  output logic [6:0]         knot_count
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 1);

  qsf_pkg::state_t state, state_next;
  qsf_pkg::phase_t phase;
  qsf_pkg::err_t   res_err;

  logic [CW-1:0]      cnt;
  logic [AW-1:0]      k;
  logic signed [31:0] xin, yin, x1, prev_x, yi, res_val;
  logic signed [32:0] h, dy;
  logic [31:0]        d;
  logic signed [47:0] cb, newa, newb;
  logic signed [127:0] acc;
  logic               neg, res_found;

  logic [qsf_pkg::MCW-1:0] m_cand;
  logic [qsf_pkg::MPW-1:0] m_plier;
  logic [qsf_pkg::DNW-1:0] d_num;
  logic [qsf_pkg::DDW-1:0] d_den;
  logic                    mul_start, mul_done, div_start, div_done;
  logic [qsf_pkg::PW-1:0]  prod;
  logic [qsf_pkg::DNW-1:0] quo;

  qsf_pkg::knot_t knot_mem [MAX_KNOTS];
  qsf_pkg::coef_t coef_mem [MAX_KNOTS];
  qsf_pkg::knot_t knot_rd;
  qsf_pkg::coef_t coef_rd;
  logic           knot_re, coef_re, knot_we, coef_we;
  logic [AW-1:0]  knot_ra, coef_ra, knot_wa, coef_wa;

  logic                accept, hit, last;
  logic [127:0]        prod_w;
  logic signed [47:0]  b_sat;
  logic signed [127:0] q_signed;
  logic signed [32:0]  h_new, dy_new, hp_new;

  assign in_ready = (state == qsf_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign prod_w   = 128'(prod);
  assign b_sat    = qsf_pkg::sat48(acc);
  assign q_signed = qsf_pkg::sgn128(quo, neg);
  assign h_new    = 33'(xin) - 33'($signed(knot_rd.x));
  assign dy_new   = 33'(yin) - 33'($signed(knot_rd.y));
  assign hp_new   = 33'(x1) - 33'($signed(knot_rd.x));
  assign hit      = (k != '0) && (prev_x <= xin) && (xin <= $signed(knot_rd.x));
  assign last     = (CW'(k) + CW'(1)) == cnt;

  qsf_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (m_cand),
    .mplier (m_plier),
    .done   (mul_done),
    .prod   (prod)
  );

  qsf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (d_num),
    .den   (d_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (knot_we) begin
      knot_mem[knot_wa] <= '{x: xin, y: yin};
    end
    if (knot_re) begin
      knot_rd <= knot_mem[knot_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= '{a: newa, b: newb};
    end
    if (coef_re) begin
      coef_rd <= coef_mem[coef_ra];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      qsf_pkg::ST_IDLE: begin
        if (accept) begin
          case (operation)
            qsf_pkg::OP_LOAD: begin
              if (cnt >= CW'(MAX_KNOTS)) state_next = qsf_pkg::ST_DONE;
              else if (cnt == '0)       state_next = qsf_pkg::ST_LD_WR;
              else                      state_next = qsf_pkg::ST_LD_RD;
            end
            qsf_pkg::OP_EVAL: begin
              if (cnt < CW'(2)) state_next = qsf_pkg::ST_DONE;
              else              state_next = qsf_pkg::ST_EV_ISSUE;
            end
            default: state_next = qsf_pkg::ST_DONE;
          endcase
        end
      end
      qsf_pkg::ST_LD_RD:   state_next = qsf_pkg::ST_LD_KNOT;
      qsf_pkg::ST_LD_KNOT: state_next = qsf_pkg::ST_LD_CHK;
      qsf_pkg::ST_LD_CHK: begin
        if (h == '0)           state_next = qsf_pkg::ST_DONE;
        else if (cnt == CW'(1)) state_next = qsf_pkg::ST_DIV;
        else                   state_next = qsf_pkg::ST_LD_PREV;
      end
      qsf_pkg::ST_LD_PREV: state_next = qsf_pkg::ST_LD_HP;
      qsf_pkg::ST_LD_HP:   state_next = qsf_pkg::ST_MUL;
      qsf_pkg::ST_LD_B:    state_next = qsf_pkg::ST_MUL;
      qsf_pkg::ST_LD_NUM:  state_next = qsf_pkg::ST_DIV;
      qsf_pkg::ST_LD_WR:   state_next = qsf_pkg::ST_DONE;
      qsf_pkg::ST_MUL:     state_next = qsf_pkg::ST_MUL_WAIT;
      qsf_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          case (phase)
            qsf_pkg::PH_AHP: state_next = qsf_pkg::ST_LD_B;
            qsf_pkg::PH_BH:  state_next = qsf_pkg::ST_LD_NUM;
            qsf_pkg::PH_EA1: state_next = qsf_pkg::ST_MUL;
            qsf_pkg::PH_EA2: state_next = qsf_pkg::ST_MUL;
            qsf_pkg::PH_EB:  state_next = qsf_pkg::ST_EV_SUM;
            default:         state_next = qsf_pkg::ST_DONE;
          endcase
        end
      end
      qsf_pkg::ST_DIV: state_next = qsf_pkg::ST_DIV_WAIT;
      qsf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (phase == qsf_pkg::PH_DA1) state_next = qsf_pkg::ST_DIV;
          else                          state_next = qsf_pkg::ST_LD_WR;
        end
      end
      qsf_pkg::ST_EV_ISSUE: state_next = qsf_pkg::ST_EV_CHK;
      qsf_pkg::ST_EV_CHK: begin
        if (hit)       state_next = qsf_pkg::ST_EV_SEG_RD;
        else if (last) state_next = qsf_pkg::ST_DONE;
        else           state_next = qsf_pkg::ST_EV_ISSUE;
      end
      qsf_pkg::ST_EV_SEG_RD: state_next = qsf_pkg::ST_EV_SEG;
      qsf_pkg::ST_EV_SEG:    state_next = qsf_pkg::ST_MUL;
      qsf_pkg::ST_EV_SUM:    state_next = qsf_pkg::ST_DONE;
      qsf_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = qsf_pkg::ST_IDLE;
      end
      default: state_next = qsf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    knot_re   = 1'b0;
    coef_re   = 1'b0;
    knot_we   = 1'b0;
    coef_we   = 1'b0;
    knot_ra   = k;
    coef_ra   = AW'(cnt - CW'(2));
    knot_wa   = AW'(cnt);
    coef_wa   = AW'(cnt - CW'(1));
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state)
      qsf_pkg::ST_LD_RD: begin
        knot_re = 1'b1;
        knot_ra = AW'(cnt - CW'(1));
        coef_re = 1'b1;
      end
      qsf_pkg::ST_LD_PREV: begin
        knot_re = 1'b1;
        knot_ra = AW'(cnt - CW'(2));
      end
      qsf_pkg::ST_LD_WR: begin
        knot_we = 1'b1;
        coef_we = (cnt != '0);
      end
      qsf_pkg::ST_MUL: mul_start = 1'b1;
      qsf_pkg::ST_DIV: div_start = 1'b1;
      qsf_pkg::ST_EV_ISSUE: knot_re = 1'b1;
      qsf_pkg::ST_EV_SEG_RD: begin
        knot_re = 1'b1;
        knot_ra = k - AW'(1);
        coef_re = 1'b1;
        coef_ra = k - AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qsf_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == qsf_pkg::ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        qsf_pkg::ST_IDLE: begin
          if (accept) begin
            xin       <= x_value;
            yin       <= y_value;
            res_val   <= '0;
            res_found <= 1'b0;
            k         <= '0;
            case (operation)
              qsf_pkg::OP_CLEAR: begin
                cnt     <= '0;
                res_err <= qsf_pkg::ERR_OK;
              end
              qsf_pkg::OP_LOAD: begin
                res_err <= (cnt >= CW'(MAX_KNOTS)) ? qsf_pkg::ERR_FULL : qsf_pkg::ERR_OK;
              end
              qsf_pkg::OP_EVAL: begin
                res_err <= (cnt < CW'(2)) ? qsf_pkg::ERR_FEW : qsf_pkg::ERR_OK;
              end
              default: res_err <= qsf_pkg::ERR_OK;
            endcase
          end
        end
        qsf_pkg::ST_LD_KNOT: begin
          x1 <= knot_rd.x;
          h  <= h_new;
          dy <= dy_new;
        end
        qsf_pkg::ST_LD_CHK: begin
          if (h == '0) res_err <= qsf_pkg::ERR_ZERO;
          neg   <= dy[32] ^ h[32];
          d_num <= 128'(qsf_pkg::mag33(dy)) << FRAC_BITS;
          d_den <= qsf_pkg::mag33(h);
          phase <= qsf_pkg::PH_DB;
        end
        qsf_pkg::ST_LD_HP: begin
          m_cand  <= qsf_pkg::MCW'(qsf_pkg::mag48(coef_rd.a));
          m_plier <= qsf_pkg::mag33(hp_new);
          neg     <= coef_rd.a[47] ^ hp_new[32];
          cb      <= coef_rd.b;
          phase   <= qsf_pkg::PH_AHP;
        end
        qsf_pkg::ST_MUL_WAIT: begin
          if (mul_done) begin
            case (phase)
              qsf_pkg::PH_AHP: acc <= qsf_pkg::sgn128(prod_w >> (FRAC_BITS - 1), neg) + 128'(cb);
              qsf_pkg::PH_BH:  acc <= 128'(dy) - qsf_pkg::sgn128(prod_w >> FRAC_BITS, neg);
              qsf_pkg::PH_EA1: begin
                m_cand <= prod[qsf_pkg::MCW-1:0];
                phase  <= qsf_pkg::PH_EA2;
              end
              qsf_pkg::PH_EA2: begin
                acc    <= qsf_pkg::sgn128(prod_w >> (2 * FRAC_BITS), neg);
                m_cand <= qsf_pkg::MCW'(qsf_pkg::mag48(cb));
                neg    <= cb[47];
                phase  <= qsf_pkg::PH_EB;
              end
              qsf_pkg::PH_EB: begin
                acc <= acc + qsf_pkg::sgn128(prod_w >> FRAC_BITS, neg) + 128'(yi);
              end
              default: ;
            endcase
          end
        end
        qsf_pkg::ST_LD_B: begin
          newb    <= b_sat;
          m_cand  <= qsf_pkg::MCW'(qsf_pkg::mag48(b_sat));
          m_plier <= qsf_pkg::mag33(h);
          neg     <= b_sat[47] ^ h[32];
          phase   <= qsf_pkg::PH_BH;
        end
        qsf_pkg::ST_LD_NUM: begin
          neg   <= acc[127];
          d_num <= qsf_pkg::mag128(acc) << FRAC_BITS;
          d_den <= qsf_pkg::mag33(h);
          phase <= qsf_pkg::PH_DA1;
        end
        qsf_pkg::ST_DIV_WAIT: begin
          if (div_done) begin
            case (phase)
              qsf_pkg::PH_DB: begin
                newb <= qsf_pkg::sat48(q_signed);
                newa <= '0;
              end
              qsf_pkg::PH_DA1: begin
                d_num <= quo << FRAC_BITS;
                phase <= qsf_pkg::PH_DA2;
              end
              qsf_pkg::PH_DA2: newa <= qsf_pkg::sat48(q_signed);
              default: ;
            endcase
          end
        end
        qsf_pkg::ST_LD_WR: cnt <= cnt + CW'(1);
        qsf_pkg::ST_EV_CHK: begin
          if (hit) begin
            d <= xin - prev_x;
          end else begin
            prev_x <= knot_rd.x;
            k      <= k + AW'(1);
          end
        end
        qsf_pkg::ST_EV_SEG: begin
          yi      <= knot_rd.y;
          m_cand  <= qsf_pkg::MCW'(qsf_pkg::mag48(coef_rd.a));
          m_plier <= {1'b0, d};
          neg     <= coef_rd.a[47];
          cb      <= coef_rd.b;
          phase   <= qsf_pkg::PH_EA1;
        end
        qsf_pkg::ST_EV_SUM: begin
          res_val   <= qsf_pkg::sat32(acc);
          res_found <= 1'b1;
        end
        qsf_pkg::ST_DONE: begin
          if (!out_valid || out_ready) begin
            spline_value <= res_val;
            found        <= res_found;
            error_code   <= res_err;
            knot_count   <= 7'(cnt);
          end
        end
        default: ;
      endcase
    end
  end

  `QSF_ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(MAX_KNOTS))
  `QSF_ASSERT_IMPL(a_wr_room, clk, rst, state == qsf_pkg::ST_LD_WR, cnt < CW'(MAX_KNOTS))
  `QSF_ASSERT_IMPL(a_mul_done, clk, rst, mul_done, state == qsf_pkg::ST_MUL_WAIT)
  `QSF_ASSERT_NEXT(a_out_drop, clk, rst, out_valid && out_ready && state != qsf_pkg::ST_DONE, !out_valid)

endmodule

### hw/rtl/qsf_mul.sv
// ============================================================================
// Serial multiplier
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ============================================================================
module qsf_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [qsf_pkg::MCW-1:0]  mcand,
  input  logic [qsf_pkg::MPW-1:0]  mplier,
  output logic                     done,
  output logic [qsf_pkg::PW-1:0]   prod
);

  localparam int CNTW = $clog2(qsf_pkg::MPW + 1);

  logic [qsf_pkg::MCW-1:0] cand;
  logic [CNTW-1:0]         steps;
  logic                    busy;
  logic [qsf_pkg::MCW:0]   sum;

  assign sum = {1'b0, prod[qsf_pkg::PW-1:qsf_pkg::MPW]} +
               (prod[0] ? {1'b0, cand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
        cand  <= mcand;
        prod  <= {{qsf_pkg::MCW{1'b0}}, mplier};
      end else if (busy) begin
        prod  <= {sum, prod[qsf_pkg::MPW-1:1]};
        steps <= steps + CNTW'(1);
        if (steps == CNTW'(qsf_pkg::MPW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/qsf_div.sv
// ============================================================================
// Serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
module qsf_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [qsf_pkg::DNW-1:0]  num,
  input  logic [qsf_pkg::DDW-1:0]  den,
  output logic                     done,
  output logic [qsf_pkg::DNW-1:0]  quo
);

  localparam int CNTW = $clog2(qsf_pkg::DNW + 1);

  logic [qsf_pkg::DDW-1:0] dv;
  logic [qsf_pkg::DDW-1:0] r;
  logic [CNTW-1:0]         steps;
  logic                    busy;
  logic [qsf_pkg::DDW:0]   t;
  logic [qsf_pkg::DDW:0]   diff;
  logic                    ge;

  assign t    = {r, quo[qsf_pkg::DNW-1]};
  assign ge   = t >= {1'b0, dv};
  assign diff = t - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
        dv    <= den;
        r     <= '0;
        quo   <= num;
      end else if (busy) begin
        r     <= ge ? diff[qsf_pkg::DDW-1:0] : t[qsf_pkg::DDW-1:0];
        quo   <= {quo[qsf_pkg::DNW-2:0], ge};
        steps <= steps + CNTW'(1);
        if (steps == CNTW'(qsf_pkg::DNW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### dv/tb.sv
// ============================================================================
// Quadratic spline block testbench
// Drives clear, load, evaluate and unused-code requests with random gaps on
// both sides; a scoreboard's fixed-point predictor checks every result.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 6000;
  localparam int ITEM_GOAL = 1400;

  typedef struct {
    logic signed [31:0] value;
    logic               hit;
    logic [1:0]         err;
    logic [6:0]         count;
  } spline_result_t;

  class spline_scoreboard;
    logic signed [31:0] kx[TABLE_DEPTH];
    logic signed [31:0] ky[TABLE_DEPTH];
    logic signed [47:0] ca[TABLE_DEPTH];
    logic signed [47:0] cb[TABLE_DEPTH];
    int                 knots;
    spline_result_t     pending[$];
    int                 mismatches;

    function new();
      knots = 0;
      mismatches = 0;
    endfunction

    function logic [127:0] mag(logic signed [127:0] v);
      return v < 0 ? -v : v;
    endfunction

    function logic signed [127:0] apply_sign(logic [127:0] m, bit neg);
      return neg ? -$signed(m) : $signed(m);
    endfunction

    function logic signed [127:0] clamp(logic signed [127:0] v, int bits);
      logic signed [127:0] top, bottom;
      top = (128'sd1 <<< (bits - 1)) - 128'sd1;
      bottom = -(128'sd1 <<< (bits - 1));
      if (v > top) return top;
      if (v < bottom) return bottom;
      return v;
    endfunction

    function qsf_pkg::err_t fit_knot(logic signed [31:0] x, logic signed [31:0] y);
      logic signed [127:0] h, dy, hp, ap, bp, t, b, num, a;
      logic [127:0] m;
      int p;
      if (knots >= TABLE_DEPTH) return qsf_pkg::ERR_FULL;
      if (knots == 0) begin
        kx[0] = x;
        ky[0] = y;
        knots = 1;
        return qsf_pkg::ERR_OK;
      end
      h = 128'(x) - 128'(kx[knots-1]);
      if (h == 0) return qsf_pkg::ERR_ZERO;
      dy = 128'(y) - 128'(ky[knots-1]);
      if (knots == 1) begin
        m = (mag(dy) << FRAC) / mag(h);
        ca[0] = '0;
        cb[0] = 48'(clamp(apply_sign(m, (dy < 0) != (h < 0)), 48));
      end else begin
        p = knots - 2;
        hp = 128'(kx[knots-1]) - 128'(kx[p]);
        ap = ca[p];
        bp = cb[p];
        t = apply_sign((mag(ap) * mag(hp)) >> (FRAC - 1), (ap < 0) != (hp < 0)) + bp;
        b = clamp(t, 48);
        num = dy - apply_sign((mag(b) * mag(h)) >> FRAC, (b < 0) != (h < 0));
        m = mag(num);
        m = (m << FRAC) / mag(h);
        m = (m << FRAC) / mag(h);
        a = clamp(apply_sign(m, num < 0), 48);
        cb[knots-1] = 48'(b);
        ca[knots-1] = 48'(a);
      end
      kx[knots] = x;
      ky[knots] = y;
      knots = knots + 1;
      return qsf_pkg::ERR_OK;
    endfunction

    function void note_request(qsf_pkg::op_t op, logic signed [31:0] x,
                               logic signed [31:0] y);
      spline_result_t r;
      logic signed [127:0] a, b, s;
      logic [127:0] d, ta;
      r.value = '0;
      r.hit = 1'b0;
      r.err = qsf_pkg::ERR_OK;
      if (op == qsf_pkg::OP_CLEAR) begin
        knots = 0;
      end else if (op == qsf_pkg::OP_LOAD) begin
        r.err = fit_knot(x, y);
      end else if (op == qsf_pkg::OP_EVAL) begin
        if (knots < 2) begin
          r.err = qsf_pkg::ERR_FEW;
        end else begin
          for (int i = 0; i + 1 < knots; i++) begin
            if (kx[i] <= x && x <= kx[i+1]) begin
              d = 128'(x) - 128'(kx[i]);
              a = ca[i];
              b = cb[i];
              ta = (mag(a) * d * d) >> (2 * FRAC);
              s = apply_sign(ta, a < 0) + apply_sign((mag(b) * d) >> FRAC, b < 0)
                  + 128'(ky[i]);
              r.value = 32'(clamp(s, 32));
              r.hit = 1'b1;
              break;
            end
          end
        end
      end
      r.count = 7'(knots);
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(spline_result_t got);
      spline_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%0d", got.value);
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value || got.hit !== want.hit || got.err !== want.err ||
          got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected value=%0d found=%0d err=%0d count=%0d,",
                    " got value=%0d found=%0d err=%0d count=%0d"},
                   want.value, want.hit, want.err, want.count,
                   got.value, got.hit, got.err, got.count);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         operation;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] spline_value;
  logic               found;
  logic [1:0]         error_code;
  logic [6:0]         knot_count;

  spline_scoreboard sb;
  int  items_sent;
  int  idle_cycles;
  bit  calm_out;

  quadratic_spline_fit_and_eval uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .x_value(x_value), .y_value(y_value),
    .out_valid(out_valid), .out_ready(out_ready), .spline_value(spline_value),
    .found(found), .error_code(error_code), .knot_count(knot_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_request(qsf_pkg::op_t op, logic signed [31:0] x,
                              logic signed [31:0] y);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    x_value <= x;
    y_value <= y;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, x, y);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic spline_sequence();
    int k, e;
    logic signed [31:0] x0, xl, xc, yv;
    bit wide_y;
    send_request(qsf_pkg::OP_CLEAR, $urandom, $urandom);
    k = ($urandom_range(0, 29) == 0) ? 66 : $urandom_range(2, 8);
    x0 = $signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
    xc = x0;
    wide_y = $urandom_range(0, 3) == 0;
    for (int i = 0; i < k; i++) begin
      yv = wide_y ? $urandom : $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      send_request(qsf_pkg::OP_LOAD, xc, yv);
      case ($urandom_range(0, 19))
        0: xc = xc;
        1: xc = xc - $signed($urandom_range(1, 32'h0001_0000));
        2: xc = xc + $signed($urandom_range(1, 16));
        default: xc = xc + $signed($urandom_range(1, 32'h0010_0000));
      endcase
    end
    xl = xc;
    e = $urandom_range(2, 8);
    for (int i = 0; i < e; i++) begin
      case ($urandom_range(0, 5))
        0: send_request(qsf_pkg::OP_EVAL, $urandom, $urandom);
        1: send_request(qsf_pkg::OP_EVAL, x0, $urandom);
        default: send_request(qsf_pkg::OP_EVAL, x0 + $signed($urandom_range(0,
                                  (xl > x0) ? 32'(xl - x0) : 0)), $urandom);
      endcase
    end
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = qsf_pkg::OP_CLEAR;
    x_value = '0;
    y_value = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(qsf_pkg::OP_CLEAR, 0, 0);
    send_request(qsf_pkg::OP_EVAL, 0, 0);
    send_request(qsf_pkg::OP_LOAD, 0, 0);
    send_request(qsf_pkg::OP_EVAL, 0, 0);
    send_request(qsf_pkg::OP_LOAD, 0, 32'sh0001_0000);
    send_request(qsf_pkg::OP_LOAD, 32'sh0001_0000, 32'sh0002_0000);
    send_request(qsf_pkg::OP_LOAD, 32'sh0003_0000, 32'sh7fff_ffff);
    send_request(qsf_pkg::OP_LOAD, 32'sh0002_0000, 32'sh8000_0000);
    send_request(qsf_pkg::OP_LOAD, 32'sh7fff_ffff, 32'sh8000_0000);
    send_request(qsf_pkg::OP_EVAL, 0, 0);
    send_request(qsf_pkg::OP_EVAL, 32'sh0000_8000, 0);
    send_request(qsf_pkg::OP_EVAL, 32'sh0003_0000, 0);
    send_request(qsf_pkg::OP_EVAL, 32'sh7fff_ffff, 0);
    send_request(qsf_pkg::OP_EVAL, 32'sh8000_0000, 0);
    send_request(qsf_pkg::op_t'(2'd3), 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_request(qsf_pkg::OP_LOAD, 32'sh8000_0000, 32'sh7fff_ffff);
    send_request(qsf_pkg::OP_EVAL, 32'sh4000_0000, 0);
    send_request(qsf_pkg::OP_CLEAR, 0, 0);
    send_request(qsf_pkg::OP_LOAD, 32'sh8000_0000, 32'sh7fff_ffff);
    send_request(qsf_pkg::OP_LOAD, 32'sh7fff_ffff, 32'sh8000_0000);
    send_request(qsf_pkg::OP_EVAL, 0, 0);
    send_request(qsf_pkg::OP_EVAL, 32'sh8000_0000, 0);

    drain();
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 99) < 80) begin
        spline_sequence();
      end else begin
        repeat ($urandom_range(1, 6))
          send_request(qsf_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom);
      end
      if ($urandom_range(0, 39) == 0) drain();
    end

    drain();
    repeat (400) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    spline_result_t got;
    int gap;
    forever begin
      if ($urandom_range(0, 49) == 0) calm_out = ~calm_out;
      gap = calm_out ? 0 : draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      got.value = spline_value;
      got.hit = found;
      got.err = error_code;
      got.count = knot_count;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

endmodule
